/* rtl/fis_pkg.sv */
// Shared types, constants and command codes for the Feistel index shuffler.
// No dependencies; every other file of the block imports this package.
package fis_pkg;

    // Field and domain sizes
    localparam int DATA_W      = 64;
    localparam int DOMAIN_BITS = 64;
    localparam int ROUNDS      = 4;
    localparam int WALK_LIMIT  = 512;
    localparam int HALF_MAX    = DOMAIN_BITS / 2;
    localparam int HW_W        = $clog2(HALF_MAX + 1);
    localparam int PAIR_CNT    = DATA_W / 2;
    localparam int PCNT_W      = $clog2(PAIR_CNT + 1);
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int WALK_W      = $clog2(WALK_LIMIT);
    localparam int CFG_IDX_W   = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUFFLE = 2'd2;

    // Request op codes
    localparam logic OP_NEXT = 1'b0;
    localparam logic OP_SEEK = 1'b1;

    // splitmix64 finalizer constants
    localparam logic [DATA_W-1:0] MIX_C0 = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [DATA_W-1:0] MIX_C1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [DATA_W-1:0] MIX_C2 = 64'h94D0_49BB_1331_11EB;
    localparam int MIX_SH0     = 30;
    localparam int MIX_SH1     = 27;
    localparam int MIX_SH2     = 31;
    localparam int ROUND_SHIFT = 56;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] seek_position;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] block_index;
        logic              seek_ok;
        logic              walk_done;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_PRE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_UPDATE,
        ST_CHECK,
        ST_FINISH
    } fis_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_START,
        DP_PRE,
        DP_MUL_A,
        DP_MUL_B,
        DP_MUL_C,
        DP_UPDATE,
        DP_CHECK,
        DP_OUT
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t             op;
        logic               mix_sel;  // 0: first mix of a round, 1: second
        logic               mul_sel;  // 0: first multiply of a mix, 1: second
        logic [ROUND_W-1:0] round;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_seek;
        logic shuffle;
        logic hit;
        logic out_valid;
    } dp_sts_t;

endpackage

/* rtl/fis_ctrl.sv */
// Sequencer of the Feistel index shuffler: state machine, round, mix and walk counters.
// Depends on fis_pkg; drives fis_datapath through dp_cmd_t.
module fis_ctrl
    import fis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  logic    rsp_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    fis_state_t         state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               mix_reg, mix_next;
    logic               mul_reg, mul_next;
    logic [WALK_W-1:0]  walk_reg, walk_next;

    // State and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            mix_reg   <= 1'b0;
            mul_reg   <= 1'b0;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            mix_reg   <= mix_next;
            mul_reg   <= mul_next;
            walk_reg  <= walk_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        mix_next    = mix_reg;
        mul_next    = mul_reg;
        walk_next   = walk_reg;
        req_ready   = 1'b0;
        cmd.op      = DP_NOP;
        cmd.mix_sel = mix_reg;
        cmd.mul_sel = mul_reg;
        cmd.round   = round_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.op     = DP_START;
                round_next = '0;
                mix_next   = 1'b0;
                mul_next   = 1'b0;
                walk_next  = '0;
                state_next = (sts.op_seek || !sts.shuffle) ? ST_FINISH : ST_PRE;
            end
            ST_PRE:
            begin
                cmd.op     = DP_PRE;
                mul_next   = 1'b0;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.op     = DP_MUL_A;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.op     = DP_MUL_B;
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                cmd.op = DP_MUL_C;
                if (!mul_reg)
                begin
                    mul_next   = 1'b1;
                    state_next = ST_MUL_A;
                end
                else if (!mix_reg)
                begin
                    mix_next   = 1'b1;
                    state_next = ST_PRE;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.op = DP_UPDATE;
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                    mix_next   = 1'b0;
                    state_next = ST_PRE;
                end
            end
            ST_CHECK:
            begin
                cmd.op = DP_CHECK;
                // hit, or walk limit reached: on a miss at the limit the plain index stays in the result
                if (sts.hit || (walk_reg == WALK_W'(WALK_LIMIT - 1)))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    walk_next  = walk_reg + 1'b1;
                    round_next = '0;
                    mix_next   = 1'b0;
                    state_next = ST_PRE;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_valid || rsp_ready)
                begin
                    cmd.op     = DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/fis_datapath.sv */
// Datapath of the Feistel index shuffler: configuration, counter, Feistel halves,
// shared 32x32 multiplier for splitmix64, and the response register. Uses fis_pkg.
module fis_datapath
    import fis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  req_t                 req_data,
    output rsp_t                 rsp_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    // Control and architectural state (reset)
    logic [DATA_W-1:0]   total_reg, total_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic                shuf_reg, shuf_next;
    logic [DATA_W-1:0]   pos_reg, pos_next;
    logic [HW_W-1:0]     half_reg, half_next;
    logic                out_valid_reg, out_valid_next;

    // Working registers (no reset)
    logic                op_reg, op_next;
    logic [DATA_W-1:0]   seek_reg, seek_next;
    logic [DATA_W-1:0]   res_idx_reg, res_idx_next;
    logic                ok_reg, ok_next;
    logic [HALF_MAX-1:0] l_reg, l_next;
    logic [HALF_MAX-1:0] r_reg, r_next;
    logic [DATA_W-1:0]   z_reg, z_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    rsp_t                rsp_reg, rsp_next;

    // Combinational helpers
    logic [DATA_W-1:0]   cm1;
    logic [PAIR_CNT-1:0] above;
    logic [PCNT_W-1:0]   ones_cnt;
    logic [DATA_W-1:0]   mask;
    logic [DATA_W-1:0]   perm_y;
    logic [DATA_W-1:0]   pre_in;
    logic [DATA_W-1:0]   pre_sum;
    logic [DATA_W-1:0]   mul_const;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [DATA_W-1:0]   prod;
    logic [DATA_W-1:0]   mul_sum;

    // Half width from total: count bit pairs of total-1 with anything set above
    always_comb
    begin
        cm1 = (total_reg == '0) ? '0 : total_reg - 1'b1;
        for (int k = 0; k < PAIR_CNT; k++)
        begin
            above[k] = |(cm1 >> (2 * k));
        end
        ones_cnt = PCNT_W'($countones(above));
        if (ones_cnt == '0)
            half_next = HW_W'(1);
        else if (ones_cnt > PCNT_W'(HALF_MAX))
            half_next = HW_W'(HALF_MAX);
        else
            half_next = HW_W'(ones_cnt);
    end

    // Feistel helpers
    assign mask   = (64'd1 << half_reg) - 64'd1;
    assign perm_y = (DATA_W'(l_reg) << half_reg) | DATA_W'(r_reg);

    // Mix entry: add golden constant and first xor-shift
    assign pre_in  = cmd.mix_sel ? (z_reg ^ key_reg)
                                 : (DATA_W'(r_reg) ^ key_reg
                                    ^ (DATA_W'(cmd.round) << ROUND_SHIFT));
    assign pre_sum = pre_in + MIX_C0;

    // Shared multiplier: low 64 bits of z * C as three 32x32 partial products
    assign mul_const = cmd.mul_sel ? MIX_C2 : MIX_C1;
    assign mul_a     = (cmd.op == DP_MUL_C) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = (cmd.op == DP_MUL_B) ? mul_const[63:32] : mul_const[31:0];
    assign prod      = DATA_W'(mul_a) * DATA_W'(mul_b);
    assign mul_sum   = acc_reg + {prod[31:0], 32'd0};

    // Next-state logic
    always_comb
    begin
        total_next     = total_reg;
        key_next       = key_reg;
        shuf_next      = shuf_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        seek_next      = seek_reg;
        res_idx_next   = res_idx_reg;
        ok_next        = ok_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        rsp_next       = rsp_reg;

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TOTAL:   total_next = cfg_data;
                CFG_KEY:     key_next   = cfg_data;
                CFG_SHUFFLE: shuf_next  = cfg_data[0];
                default:     ;
            endcase
        end

        // response drained
        if (rsp_valid && rsp_ready)
            out_valid_next = 1'b0;

        unique case (cmd.op)
            DP_LATCH:
            begin
                op_next   = req_data.op;
                seek_next = req_data.seek_position;
            end
            DP_START:
            begin
                if (op_reg == OP_SEEK)
                begin
                    res_idx_next = '0;
                    ok_next      = (seek_reg <= total_reg);
                    if (seek_reg <= total_reg)
                        pos_next = seek_reg;
                end
                else
                begin
                    res_idx_next = pos_reg;
                    ok_next      = 1'b0;
                    pos_next     = pos_reg + 1'b1;
                    r_next       = HALF_MAX'(pos_reg & mask);
                    l_next       = HALF_MAX'((pos_reg >> half_reg) & mask);
                end
            end
            DP_PRE:
            begin
                z_next = pre_sum ^ (pre_sum >> MIX_SH0);
            end
            DP_MUL_A:
            begin
                acc_next = prod;
            end
            DP_MUL_B:
            begin
                acc_next = mul_sum;
            end
            DP_MUL_C:
            begin
                if (cmd.mul_sel)
                    z_next = mul_sum ^ (mul_sum >> MIX_SH2);
                else
                    z_next = mul_sum ^ (mul_sum >> MIX_SH1);
            end
            DP_UPDATE:
            begin
                l_next = r_reg;
                r_next = l_reg ^ HALF_MAX'(z_reg & mask);
            end
            DP_CHECK:
            begin
                if (perm_y < total_reg)
                    res_idx_next = perm_y;
            end
            DP_OUT:
            begin
                rsp_next.block_index = res_idx_reg;
                rsp_next.seek_ok     = ok_reg;
                rsp_next.walk_done   = (pos_reg >= total_reg);
                out_valid_next       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            key_reg       <= '0;
            shuf_reg      <= 1'b0;
            pos_reg       <= '0;
            half_reg      <= HW_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            key_reg       <= key_next;
            shuf_reg      <= shuf_next;
            pos_reg       <= pos_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        seek_reg    <= seek_next;
        res_idx_reg <= res_idx_next;
        ok_reg      <= ok_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        z_reg       <= z_next;
        acc_reg     <= acc_next;
        rsp_reg     <= rsp_next;
    end

    // Status and outputs
    assign sts.op_seek   = (op_reg == OP_SEEK);
    assign sts.shuffle   = shuf_reg;
    assign sts.hit       = (perm_y < total_reg);
    assign sts.out_valid = out_valid_reg;
    assign rsp_valid     = out_valid_reg;
    assign rsp_data      = rsp_reg;

endmodule

/* rtl/feistel_index_shuffler.sv */
// Seek, or next in ascending order: latched in idle, then the start and finish states queue the response.
// Shuffled next: w = 1..512 permutations of the walk; each permutation is
// 4 rounds (two splitmix64 passes on one shared 32x32 multiplier) plus a check.
// Throughput: one request at a time; the next is taken the cycle after the response is queued.
// Reset: asynchronous, active low; control registers cleared, half width 1, ready right after reset.
module feistel_index_shuffler
    import fis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Configuration writes are taken in any cycle
    assign cfg_ready = 1'b1;

    fis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fis_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req_data),
        .rsp_data  (rsp_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* rtl/fis_checker.sv */
// Port-level checks for feistel_index_shuffler, attached by the bind at the end.
// Uses fis_pkg for the request and response types.
module fis_checker
    import fis_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input rsp_t                 rsp_data
);

    logic [1:0] pend_reg, pend_next;

    // Requests taken minus responses delivered
    always_comb
    begin
        pend_next = pend_reg;
        if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
            pend_next = pend_reg + 1'b1;
        else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // no response without a request behind it
    assert property (@(posedge clk) disable iff (!rst_n) rsp_valid |-> pend_reg != 2'd0)
        else $error("response with no request pending");

    // at most one request in work and one response waiting
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg <= 2'd2)
        else $error("too many requests in flight");

    // a full block stops taking requests
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg == 2'd2 |-> !req_ready)
        else $error("request taken with two pending");

    // an accepted seek reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.seek_ok) |-> rsp_data.block_index == '0)
        else $error("seek response with nonzero index");

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled response changed");

endmodule

bind feistel_index_shuffler fis_checker u_fis_checker (.*);
